[rtl/core/otes_pkg.sv]
package otes_pkg;

  localparam int MODE_W   = 2;
  localparam int TREE_W   = 6;
  localparam int LEVEL_W  = 3;
  localparam int FEAT_W   = 8;
  localparam int LEAF_W   = 8;
  localparam int VAL_W    = 32;
  localparam int SCORE_W  = 48;
  localparam int COUNT_W  = 7;
  localparam int DEPTH_W  = 4;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd1;
  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 4'd6;

  // register select is paddr[2]
  localparam logic REG_TREE_COUNT = 1'b0;
  localparam logic REG_TREE_DEPTH = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    OP_NODE   = 2'd0,
    OP_LEAF   = 2'd1,
    OP_WEIGHT = 2'd2,
    OP_FEAT   = 2'd3
  } op_t;

  typedef struct packed {
    op_t                     op;
    logic                    ok;
    logic                    last;
    logic [TREE_W-1:0]       tree;
    logic [LEVEL_W-1:0]      level;
    logic [FEAT_W-1:0]       feat;
    logic [LEAF_W-1:0]       leaf;
    logic signed [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic clearing;
    logic scoring;
  } stat_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_LEVEL,
    ST_FEAT,
    ST_CMP,
    ST_LEAF,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } back_state_t;

endpackage

[rtl/core/otes_ifs.sv]
interface otes_in_if;
  import otes_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [MODE_W-1:0]       mode;
  logic [TREE_W-1:0]       tree_index;
  logic [LEVEL_W-1:0]      level_index;
  logic [FEAT_W-1:0]       feature_index;
  logic [LEAF_W-1:0]       leaf_index;
  logic signed [VAL_W-1:0] value;
  logic                    last_feature;

  modport source(output valid, mode, tree_index, level_index, feature_index, leaf_index,
                 value, last_feature, input ready);
  modport sink(input valid, mode, tree_index, level_index, feature_index, leaf_index,
               value, last_feature, output ready);
endinterface

interface otes_out_if;
  import otes_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [SCORE_W-1:0] score;
  logic                      saturated;

  modport source(output valid, score, saturated, input ready);
  modport sink(input valid, score, saturated, output ready);
endinterface

[rtl/core/otes_front.sv]
module otes_front #(
  parameter int MAX_TREES     = 64,
  parameter int MAX_DEPTH     = 8,
  parameter int FEATURE_COUNT = 256
) (
  otes_in_if.sink         in_ch,
  input  otes_pkg::stat_t stat,
  input  logic            q_full,
  output logic            push,
  output otes_pkg::cmd_t  cmd
);
  import otes_pkg::*;

  logic tree_ok, level_ok, leaf_ok, feat_ok;

  assign in_ch.ready = !q_full && !stat.clearing;
  assign push        = in_ch.valid && in_ch.ready;

  assign tree_ok  = 32'(in_ch.tree_index) < MAX_TREES;
  assign level_ok = 32'(in_ch.level_index) < MAX_DEPTH;
  assign leaf_ok  = 32'(in_ch.leaf_index) < (32'd1 << MAX_DEPTH);
  assign feat_ok  = 32'(in_ch.feature_index) < FEATURE_COUNT;

  always_comb begin
    cmd.op    = op_t'(in_ch.mode);
    cmd.last  = in_ch.last_feature && (cmd.op == OP_FEAT);
    cmd.tree  = in_ch.tree_index;
    cmd.level = in_ch.level_index;
    cmd.feat  = in_ch.feature_index;
    cmd.leaf  = in_ch.leaf_index;
    cmd.value = in_ch.value;
    unique case (cmd.op)
      OP_NODE:   cmd.ok = tree_ok && level_ok;
      OP_LEAF:   cmd.ok = tree_ok && leaf_ok;
      OP_WEIGHT: cmd.ok = tree_ok;
      OP_FEAT:   cmd.ok = feat_ok;
      default:   cmd.ok = 1'b0;
    endcase
  end

endmodule

[rtl/core/otes_queue.sv]
module otes_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  otes_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           q_valid,
  output logic           q_full,
  output otes_pkg::cmd_t q_cmd
);
  import otes_pkg::*;

  cmd_t       slot_r [2];
  logic       wr_r, wr_nxt;
  logic       rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign q_valid = cnt_r != 2'd0;
  assign q_full  = cnt_r == 2'd2;
  assign q_cmd   = slot_r[rd_r];

  always_comb begin
    wr_nxt  = push ? !wr_r : wr_r;
    rd_nxt  = pop ? !rd_r : rd_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_cmd;
    end
  end

endmodule

[rtl/core/otes_back.sv]
module otes_back #(
  parameter int MAX_TREES     = 64,
  parameter int MAX_DEPTH     = 8,
  parameter int FEATURE_COUNT = 256
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_valid,
  input  otes_pkg::cmd_t                   q_cmd,
  output logic                             pop,
  input  logic [otes_pkg::COUNT_W-1:0]     tree_count,
  input  logic [otes_pkg::DEPTH_W-1:0]     tree_depth,
  output otes_pkg::stat_t                  stat,
  otes_out_if.source                       out_ch
);
  import otes_pkg::*;

  localparam int TI_W   = (MAX_TREES > 1) ? $clog2(MAX_TREES) : 1;
  localparam int TN_W   = $clog2(MAX_TREES + 1);
  localparam int LV_W   = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int LC_W   = $clog2(MAX_DEPTH + 1);
  localparam int NODE_D = MAX_TREES * MAX_DEPTH;
  localparam int NA_W   = (NODE_D > 1) ? $clog2(NODE_D) : 1;
  localparam int LA_W   = TI_W + MAX_DEPTH;
  localparam int FA_W   = $clog2(FEATURE_COUNT);
  localparam int PROD_W = 2 * VAL_W;

  localparam logic signed [SCORE_W-1:0] ACC_MAX = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam logic signed [SCORE_W-1:0] ACC_MIN = {1'b1, {(SCORE_W-1){1'b0}}};

  logic signed [VAL_W-1:0] feat_mem   [FEATURE_COUNT];
  logic [FEAT_W-1:0]       nfeat_mem  [NODE_D];
  logic signed [VAL_W-1:0] nthr_mem   [NODE_D];
  logic signed [VAL_W-1:0] leaf_mem   [MAX_TREES * (2 ** MAX_DEPTH)];
  logic signed [VAL_W-1:0] weight_mem [MAX_TREES];

  back_state_t state_r, state_nxt;

  logic [FA_W-1:0]           clr_r, clr_nxt;
  logic [TI_W-1:0]           t_r, t_nxt;
  logic [TN_W-1:0]           n_r, n_nxt;
  logic [LC_W-1:0]           d_r, d_nxt;
  logic [LC_W-1:0]           lvl_r, lvl_nxt;
  logic [MAX_DEPTH-1:0]      idx_r, idx_nxt;
  logic signed [SCORE_W-1:0] acc_r, acc_nxt;
  logic                      sat_r, sat_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [SCORE_W-1:0] score_r;
  logic                      osat_r;
  logic                      out_load;

  logic [FEAT_W-1:0]         nfeat_q;
  logic signed [VAL_W-1:0]   nthr_q;
  logic signed [VAL_W-1:0]   feat_q;
  logic signed [VAL_W-1:0]   leaf_q;
  logic signed [VAL_W-1:0]   weight_q;
  logic signed [PROD_W-1:0]  prod_r;

  logic [NA_W-1:0]           node_rd_addr, node_wr_addr;
  logic [LA_W-1:0]           leaf_rd_addr, leaf_wr_addr;
  logic [FA_W-1:0]           feat_rd_addr;
  logic                      node_oor_r;
  logic signed [VAL_W-1:0]   fv;
  logic signed [SCORE_W:0]   sum;
  logic                      last_tree;

  assign stat.clearing = state_r == ST_CLEAR;
  assign stat.scoring  = state_r != ST_CLEAR && state_r != ST_IDLE;

  assign pop = (state_r == ST_IDLE) && q_valid;

  assign node_rd_addr = NA_W'(32'(t_r) * MAX_DEPTH + 32'(lvl_r));
  assign node_wr_addr = NA_W'(32'(q_cmd.tree) * MAX_DEPTH + 32'(q_cmd.level));
  assign leaf_rd_addr = {t_r, idx_r};
  assign leaf_wr_addr = {TI_W'(q_cmd.tree), MAX_DEPTH'(q_cmd.leaf)};
  assign feat_rd_addr = FA_W'(nfeat_q);

  assign fv        = node_oor_r ? '0 : feat_q;
  // product is Q32.32, dropping 16 bits with arithmetic shift rounds toward minus infinity
  assign sum       = {acc_r[SCORE_W-1], acc_r} + {prod_r[PROD_W-1], prod_r[PROD_W-1:16]};
  assign last_tree = (32'(t_r) + 32'd1) == 32'(n_r);
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (32'(clr_r) == FEATURE_COUNT - 1) state_nxt = ST_IDLE;
      ST_IDLE:  if (q_valid && q_cmd.last) state_nxt = ST_START;
      ST_START: state_nxt = (n_nxt == '0) ? ST_DONE : ST_LEVEL;
      ST_LEVEL: state_nxt = (lvl_r == d_r) ? ST_LEAF : ST_FEAT;
      ST_FEAT:  state_nxt = ST_CMP;
      ST_CMP:   state_nxt = ST_LEVEL;
      ST_LEAF:  state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_ACC;
      ST_ACC:   state_nxt = last_tree ? ST_DONE : ST_LEVEL;
      ST_DONE:  if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath updates
  always_comb begin
    clr_nxt       = clr_r;
    t_nxt         = t_r;
    n_nxt         = n_r;
    d_nxt         = d_r;
    lvl_nxt       = lvl_r;
    idx_nxt       = idx_r;
    acc_nxt       = acc_r;
    sat_nxt       = sat_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    unique case (state_r)
      ST_CLEAR: clr_nxt = clr_r + 1'b1;
      ST_START: begin
        n_nxt   = (32'(tree_count) > MAX_TREES) ? TN_W'(MAX_TREES) : TN_W'(tree_count);
        d_nxt   = (32'(tree_depth) > MAX_DEPTH) ? LC_W'(MAX_DEPTH) : LC_W'(tree_depth);
        t_nxt   = '0;
        lvl_nxt = '0;
        idx_nxt = '0;
        acc_nxt = '0;
        sat_nxt = 1'b0;
      end
      ST_CMP: begin
        if (fv <= nthr_q) idx_nxt[lvl_r[LV_W-1:0]] = 1'b1;
        lvl_nxt = lvl_r + 1'b1;
      end
      ST_ACC: begin
        if (sum[SCORE_W] != sum[SCORE_W-1]) begin
          acc_nxt = sum[SCORE_W] ? ACC_MIN : ACC_MAX;
          sat_nxt = 1'b1;
        end else begin
          acc_nxt = sum[SCORE_W-1:0];
        end
        t_nxt   = t_r + 1'b1;
        lvl_nxt = '0;
        idx_nxt = '0;
      end
      ST_DONE: if (out_load) out_valid_nxt = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r    <= t_nxt;
    n_r    <= n_nxt;
    d_r    <= d_nxt;
    lvl_r  <= lvl_nxt;
    idx_r  <= idx_nxt;
    acc_r  <= acc_nxt;
    sat_r  <= sat_nxt;
    prod_r <= leaf_q * weight_q;
    if (out_load) begin
      score_r <= acc_r;
      osat_r  <= sat_r;
    end
  end

  // feature store: cleared after reset, then written by feature requests
  always_ff @(posedge clk) begin
    if (state_r == ST_CLEAR) begin
      feat_mem[clr_r] <= '0;
    end else if (pop && q_cmd.op == OP_FEAT && q_cmd.ok) begin
      feat_mem[FA_W'(q_cmd.feat)] <= q_cmd.value;
    end
    feat_q <= feat_mem[feat_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (pop && q_cmd.op == OP_NODE && q_cmd.ok) begin
      nfeat_mem[node_wr_addr] <= q_cmd.feat;
      nthr_mem[node_wr_addr]  <= q_cmd.value;
    end
    if (state_r == ST_LEVEL) begin
      nfeat_q <= nfeat_mem[node_rd_addr];
      nthr_q  <= nthr_mem[node_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    node_oor_r <= 32'(nfeat_q) >= FEATURE_COUNT;
  end

  always_ff @(posedge clk) begin
    if (pop && q_cmd.op == OP_LEAF && q_cmd.ok) begin
      leaf_mem[leaf_wr_addr] <= q_cmd.value;
    end
    leaf_q <= leaf_mem[leaf_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (pop && q_cmd.op == OP_WEIGHT && q_cmd.ok) begin
      weight_mem[TI_W'(q_cmd.tree)] <= q_cmd.value;
    end
    weight_q <= weight_mem[t_r];
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.score     = score_r;
  assign out_ch.saturated = osat_r;

endmodule

[rtl/core/oblivious_tree_ensemble_scorer.sv]
// oblivious tree ensemble scorer
// in_ch carries load and feature requests (valid/ready); mode selects node load,
// leaf load, weight load or feature value. out_ch delivers one score per document.
// configuration: tree_count at byte 0, tree_depth at byte 4 over the apb port,
// written by the user only while the block is idle; the block does not enforce it.
// a two-entry queue parts request intake from the back end that owns all tables.
// with the back end idle, loads and non-final features retire one per cycle at the head.
// the request marked last_feature starts a scoring pass over n trees, d levels:
// per tree, each level does a node table read, a feature store read and a compare,
// then the end-of-tree check, leaf/weight read, multiply and saturating add run;
// after the last tree the score is loaded into the output register.
// after reset the feature store is swept to zero, one entry a cycle over all
// FEATURE_COUNT entries, and in_ch.ready stays low during the sweep.
// the result stays in the output register while out_ch.ready is low; requests
// keep queueing until the queue is full, and a new pass waits to write its
// result until the previous one has been taken.
module oblivious_tree_ensemble_scorer #(
  parameter int MAX_TREES     = 64,
  parameter int MAX_DEPTH     = 8,
  parameter int FEATURE_COUNT = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  otes_in_if.sink                       in_ch,
  otes_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [otes_pkg::PADDR_W-1:0]  paddr,
  input  logic [otes_pkg::PDATA_W-1:0]  pwdata,
  output logic [otes_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import otes_pkg::*;

  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;
  logic               wr_en;
  logic               push, pop, q_valid, q_full;
  cmd_t               push_cmd, q_cmd;
  stat_t              stat;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    count_nxt = count_r;
    depth_nxt = depth_r;
    if (wr_en) begin
      unique case (paddr[2])
        REG_TREE_COUNT: count_nxt = pwdata[COUNT_W-1:0];
        REG_TREE_DEPTH: depth_nxt = pwdata[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TREE_COUNT: prdata = PDATA_W'(count_r);
      REG_TREE_DEPTH: prdata = PDATA_W'(depth_r);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= COUNT_RESET;
      depth_r <= DEPTH_RESET;
    end else begin
      count_r <= count_nxt;
      depth_r <= depth_nxt;
    end
  end

  otes_front #(
    .MAX_TREES(MAX_TREES), .MAX_DEPTH(MAX_DEPTH), .FEATURE_COUNT(FEATURE_COUNT)
  ) u_front (
    .in_ch (in_ch),
    .stat  (stat),
    .q_full(q_full),
    .push  (push),
    .cmd   (push_cmd)
  );

  otes_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .q_valid (q_valid),
    .q_full  (q_full),
    .q_cmd   (q_cmd)
  );

  otes_back #(
    .MAX_TREES(MAX_TREES), .MAX_DEPTH(MAX_DEPTH), .FEATURE_COUNT(FEATURE_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .tree_count(count_r),
    .tree_depth(depth_r),
    .stat      (stat),
    .out_ch    (out_ch)
  );

`ifndef SYNTHESIS
  a_no_req_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    stat.clearing |-> !in_ch.ready)
    else $error("request taken during feature store sweep");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_full))
    else $error("queue written while full");

  a_pop_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid && !stat.scoring)
    else $error("queue read while empty or while scoring");
`endif

endmodule
